// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPLF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mplf_pkg.sv =====
package mplf_pkg;

    localparam int LEVEL_W = 5;
    localparam int COUNT_W = 8;
    localparam int LAMP_W  = 8;
    localparam int GROUP_W = 2;
    localparam int TBITS_W = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [COUNT_W-1:0] t_count;

    // Input actions
    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;

    // Register indexes (word address)
    localparam logic [2:0] REG_UPPER  = 3'd0;
    localparam logic [2:0] REG_LOWER  = 3'd1;
    localparam logic [2:0] REG_FADE   = 3'd2;
    localparam logic [2:0] REG_MUX    = 3'd3;
    localparam logic [2:0] REG_PAUSED = 3'd4;

    // Register reset values
    localparam t_level RST_UPPER = 5'd16;
    localparam t_level RST_LOWER = 5'd2;
    localparam t_count RST_FADE  = 8'd10;
    localparam t_count RST_MUX   = 8'd20;

    typedef struct packed {
        t_level upper;
        t_level lower;
        t_count fade_period;
        t_count mux_period;
        logic   paused;
    } t_cfg;

    // Port bit that shows a channel: 0-2 on bits 0-2, 3-6 on bits 4-7, 7 on bit 3
    function automatic logic [2:0] port_pos(input int ch);
        logic [2:0] pos;
        if (ch < 3) begin
            pos = 3'(ch);
        end else if (ch < 7) begin
            pos = 3'(ch + 1);
        end else begin
            pos = 3'd3;
        end
        return pos;
    endfunction

endpackage

// ===== src/multiplexed_pwm_lamp_fader.sv =====
// Multiplexed PWM lamp fader.
// Path: an input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while the result is not stalled; the per-group
// fade and PWM compare run in one pass between the two registers.
// Reset (synchronous, active low) clears all lamp state and loads register defaults.
module multiplexed_pwm_lamp_fader #(
    parameter int CHANNELS  = 8,
    parameter int GROUPS    = 3,
    parameter int PWM_STEPS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_action,
    input  logic [mplf_pkg::GROUP_W-1:0] i_target_group,
    input  logic [mplf_pkg::TBITS_W-1:0] i_target_bits,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mplf_pkg::LAMP_W-1:0]  o_lamp_bits,
    output logic [mplf_pkg::GROUP_W-1:0] o_active_group,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mplf_pkg::ADDR_W-1:0]  paddr,
    input  logic [mplf_pkg::DATA_W-1:0]  pwdata,
    output logic [mplf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import mplf_pkg::*;

    localparam int PHASE_W = $clog2(PWM_STEPS + 2);
    localparam int GW      = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    t_cfg w_cfg;

    // Input stage
    logic               r_in_valid;
    logic               r_in_action;
    logic [GROUP_W-1:0] r_in_group;
    logic [TBITS_W-1:0] r_in_bits;

    // Lamp state
    t_level              r_bright [GROUPS][CHANNELS];
    logic [CHANNELS-1:0] r_target [GROUPS];
    logic [PHASE_W-1:0]  r_phase;
    t_count              r_fade_cnt;
    t_count              r_mux_cnt;
    logic [GW-1:0]       r_group;
    logic [LAMP_W-1:0]   r_lamps;
    logic                r_out_valid;

    logic                w_adv;
    logic                w_tick;
    logic                w_load;
    logic [PHASE_W-1:0]  w_phase_inc;
    logic                w_wrap;
    logic [PHASE_W-1:0]  n_phase;
    t_count              w_fade_inc;
    logic                w_fade;
    t_count              n_fade_cnt;
    t_count              w_mux_inc;
    logic                w_switch;
    logic [GW-1:0]       n_group;
    logic [CHANNELS-1:0] w_lit;
    t_level              w_next_level [CHANNELS];
    logic [LAMP_W-1:0]   w_lamps;

    mplf_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshake: process the held transaction when the result register is free
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_tick     = w_adv && (r_in_action == ACTION_TICK) && !w_cfg.paused;
    assign w_load     = w_adv && (r_in_action == ACTION_LOAD) &&
                        ((GW + 2)'(r_in_group) < (GW + 2)'(GROUPS));

    // Phase runs 1..PWM_STEPS and counts its wraps
    assign w_phase_inc = r_phase + 1'b1;
    assign w_wrap      = w_phase_inc >= PHASE_W'(PWM_STEPS + 1);
    assign n_phase     = w_wrap ? PHASE_W'(1) : w_phase_inc;
    assign w_fade_inc  = w_wrap ? r_fade_cnt + 1'b1 : r_fade_cnt;
    assign w_fade      = w_fade_inc >= w_cfg.fade_period;
    assign n_fade_cnt  = w_fade ? '0 : w_fade_inc;

    // Group switch every mux period
    assign w_mux_inc = r_mux_cnt + 1'b1;
    assign w_switch  = w_mux_inc == w_cfg.mux_period;
    assign n_group   = (r_group == GW'(GROUPS - 1)) ? '0 : r_group + 1'b1;

    // One compare and fade step per channel of the active group
    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
        mplf_chan #(
            .PHASE_W (PHASE_W)
        ) u_chan (
            .i_phase  (n_phase),
            .i_level  (r_bright[r_group][ch]),
            .i_target (r_target[r_group][ch]),
            .i_upper  (w_cfg.upper),
            .i_lower  (w_cfg.lower),
            .o_lit    (w_lit[ch]),
            .o_level  (w_next_level[ch])
        );
    end

    // Map channels onto the port pattern
    always_comb begin
        w_lamps = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (ch < LAMP_W) begin
                w_lamps[port_pos(ch)] = w_lit[ch];
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_action <= i_action;
            r_in_group  <= i_target_group;
            r_in_bits   <= i_target_bits;
        end
    end

    // Advance counters, group and lamp levels on a tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_fade_cnt <= '0;
            r_mux_cnt  <= '0;
            r_group    <= '0;
            r_lamps    <= '0;
            for (int g = 0; g < GROUPS; g++) begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    r_bright[g][ch] <= '0;
                end
            end
        end else if (w_tick) begin
            r_phase    <= n_phase;
            r_fade_cnt <= n_fade_cnt;
            r_mux_cnt  <= w_switch ? '0 : w_mux_inc;
            r_group    <= w_switch ? n_group : r_group;
            r_lamps    <= w_switch ? '0 : w_lamps;
            if (w_fade) begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    r_bright[r_group][ch] <= w_next_level[ch];
                end
            end
        end
    end

    // Load targets of one group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < GROUPS; g++) begin
                r_target[g] <= '0;
            end
        end else if (w_load) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_target[GW'(r_in_group)][ch] <= (ch < TBITS_W) ? r_in_bits[3'(ch)] : 1'b0;
            end
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_lamp_bits    = r_lamps;
    assign o_active_group = GROUP_W'(r_group);

endmodule

// ===== src/mplf_chan.sv =====
module mplf_chan #(
    parameter int PHASE_W = 5
) (
    input  logic [PHASE_W-1:0] i_phase,
    input  mplf_pkg::t_level   i_level,
    input  logic               i_target,
    input  mplf_pkg::t_level   i_upper,
    input  mplf_pkg::t_level   i_lower,
    output logic               o_lit,
    output mplf_pkg::t_level   o_level
);
    import mplf_pkg::*;

    localparam int CMP_W = (PHASE_W > LEVEL_W) ? PHASE_W : LEVEL_W;

    // Light while the phase is below the level
    assign o_lit = CMP_W'(i_phase) < CMP_W'(i_level);

    // Step toward the upper limit when on, down to the floor when off
    always_comb begin
        if (i_target) begin
            o_level = (i_level < i_upper) ? i_level + 1'b1 : i_level;
        end else begin
            o_level = (i_level > i_lower) ? i_level - 1'b1 : i_lower;
        end
    end

endmodule

// ===== src/mplf_apb.sv =====
module mplf_apb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mplf_pkg::ADDR_W-1:0] paddr,
    input  logic [mplf_pkg::DATA_W-1:0] pwdata,
    output logic [mplf_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output mplf_pkg::t_cfg              o_cfg
);
    import mplf_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // Write the addressed register in the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper       <= RST_UPPER;
            r_cfg.lower       <= RST_LOWER;
            r_cfg.fade_period <= RST_FADE;
            r_cfg.mux_period  <= RST_MUX;
            r_cfg.paused      <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_UPPER:  r_cfg.upper       <= pwdata[LEVEL_W-1:0];
                REG_LOWER:  r_cfg.lower       <= pwdata[LEVEL_W-1:0];
                REG_FADE:   r_cfg.fade_period <= pwdata[COUNT_W-1:0];
                REG_MUX:    r_cfg.mux_period  <= pwdata[COUNT_W-1:0];
                REG_PAUSED: r_cfg.paused      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            REG_UPPER:  prdata = DATA_W'(r_cfg.upper);
            REG_LOWER:  prdata = DATA_W'(r_cfg.lower);
            REG_FADE:   prdata = DATA_W'(r_cfg.fade_period);
            REG_MUX:    prdata = DATA_W'(r_cfg.mux_period);
            REG_PAUSED: prdata = DATA_W'(r_cfg.paused);
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== src/mplf_checker.sv =====
`include "assert_macros.svh"

module mplf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [mplf_pkg::LAMP_W-1:0]  o_lamp_bits,
    input logic [mplf_pkg::GROUP_W-1:0] o_active_group
);

    // Hold a stalled result
    `MPLF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_lamp_bits) && $stable(o_active_group), "stalled result changed")

    // Input stalls only behind a stalled result
    `MPLF_ASSERT_NOW(a_ready_low, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready, "input stalled without output backpressure")

    // Group and lamps change only with a fresh result
    `MPLF_ASSERT_NOW(a_group_moves, i_clk, i_rst_n, !$stable(o_active_group), o_out_valid, "group changed without a result")

    `MPLF_ASSERT_NOW(a_lamps_move, i_clk, i_rst_n, !$stable(o_lamp_bits), o_out_valid, "lamps changed without a result")

endmodule

bind multiplexed_pwm_lamp_fader mplf_checker u_mplf_checker (.*);
